>>> rtl/pdf_pkg.sv
// Shared types and constants for the packet deframer with CRC-8 check.
// No dependencies; imported by the result interface, the CRC step and the top level.
package pdf_pkg;

  localparam logic [7:0]  CRC8_POLY       = 8'h8C;
  localparam logic [15:0] ID_MASK_RESET   = 16'hF228;
  localparam int          ID_MASK_WIDTH   = 16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CRC_ERR    = 2'd1,
    ST_UNKNOWN_ID = 2'd2
  } pdf_status_t;

endpackage

>>> rtl/pdf_channels.sv
// Valid/ready channel interfaces for the deframer: byte input, result output
// and the accept-mask write port. Depends on pdf_pkg.
interface pdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdf_res_if;
  import pdf_pkg::*;
  logic        valid;
  logic        ready;
  logic        is_verdict;
  logic [7:0]  packet_id;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] payload_length;
  pdf_status_t status;

  modport source (output valid, output is_verdict, output packet_id, output data_byte,
                  output byte_index, output payload_length, output status, input ready);
  modport sink   (input valid, input is_verdict, input packet_id, input data_byte,
                  input byte_index, input payload_length, input status, output ready);
endinterface

interface pdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] accepted_id_mask;

  modport source (output valid, output accepted_id_mask, input ready);
  modport sink   (input valid, input accepted_id_mask, output ready);
endinterface

>>> rtl/pdf_crc8_step.sv
// One-byte update of the reflected Maxim CRC-8, fully combinational.
// Depends on pdf_pkg for the polynomial.
module pdf_crc8_step
  import pdf_pkg::*;
(
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data_in;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC8_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    crc_out = c;
  end

endmodule

>>> rtl/packet_deframer_crc8_unit.sv
// Packet deframer top level: parses id, length, payload and CRC byte.
// Depends on pdf_pkg, the channel interfaces and pdf_crc8_step.
// Usage:
//   in_ch carries one received byte per transfer. A packet is an id byte, a
//   little-endian 16-bit payload length, the payload bytes and one CRC byte
//   (reflected Maxim CRC-8, seed zero, payload only). Header bytes produce no
//   result. out_ch carries one transfer per payload byte (data, index, id,
//   declared length) and one verdict transfer after the CRC byte with status
//   ok, CRC error or unknown id; a CRC error wins over an unknown id.
//   cfg_ch writes the accepted id mask (bit n enables id n, ids of 16 and up
//   are never accepted). It is always ready and should only be written while
//   the block is idle.
// Timing:
//   A byte is parsed in the cycle it is transferred and its result is in the
//   output register in the cycle after; one byte per cycle is sustained while
//   out_ch stays ready. If the receiver stalls, the held result stays put and
//   in_ch accepts a byte only when the output register is empty or draining.
// Reset:
//   rst_n is synchronous. After reset the parser waits for an id byte, the
//   output register is empty and the mask enables ids 3, 5, 9, 12..15.
module packet_deframer_crc8_unit
  import pdf_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pdf_rx_if.sink      in_ch,
  pdf_res_if.source   out_ch,
  pdf_cfg_if.sink     cfg_ch
);

  typedef enum logic [2:0] {
    PH_ID      = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  // Parser state.
  phase_t                    phase_r, phase_nxt;
  logic [7:0]                id_r, id_nxt;
  logic [LENGTH_WIDTH-1:0]   len_r, len_nxt;
  logic [LENGTH_WIDTH-1:0]   count_r, count_nxt;
  logic [7:0]                crc_r, crc_nxt;
  logic [ID_MASK_WIDTH-1:0]  mask_r;

  // Output register.
  logic        out_valid_r;
  logic        res_verdict_r, res_verdict_nxt;
  logic [7:0]  res_id_r, res_id_nxt;
  logic [7:0]  res_data_r, res_data_nxt;
  logic [15:0] res_index_r, res_index_nxt;
  logic [15:0] res_len_r, res_len_nxt;
  pdf_status_t res_status_r, res_status_nxt;
  logic        has_result;

  logic                    accept;
  logic [7:0]              crc_step;
  logic [15:0]             len_full;
  logic [LENGTH_WIDTH:0]   count_inc;
  logic                    id_known;

  // The output register frees up when it is empty or drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  pdf_crc8_step u_crc (
    .crc_in  (crc_r),
    .data_in (in_ch.rx_byte),
    .crc_out (crc_step)
  );

  assign len_full  = {in_ch.rx_byte, len_r[7:0]};
  assign count_inc = {1'b0, count_r} + (LENGTH_WIDTH+1)'(1);
  assign id_known  = (id_r[7:4] == 4'd0) && mask_r[id_r[3:0]];

  always_comb begin
    phase_nxt       = phase_r;
    id_nxt          = id_r;
    len_nxt         = len_r;
    count_nxt       = count_r;
    crc_nxt         = crc_r;
    has_result      = 1'b0;
    res_verdict_nxt = 1'b0;
    res_id_nxt      = id_r;
    res_data_nxt    = 8'd0;
    res_index_nxt   = 16'd0;
    res_len_nxt     = 16'(len_r);
    res_status_nxt  = ST_OK;
    unique case (phase_r)
      PH_LEN_LO: begin
        len_nxt   = LENGTH_WIDTH'(in_ch.rx_byte);
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full[LENGTH_WIDTH-1:0];
        count_nxt = '0;
        crc_nxt   = 8'd0;
        phase_nxt = (len_full[LENGTH_WIDTH-1:0] == '0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_nxt       = crc_step;
        count_nxt     = count_inc[LENGTH_WIDTH-1:0];
        has_result    = 1'b1;
        res_data_nxt  = in_ch.rx_byte;
        res_index_nxt = 16'(count_r);
        if (count_inc >= {1'b0, len_r}) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        has_result      = 1'b1;
        res_verdict_nxt = 1'b1;
        phase_nxt       = PH_ID;
        priority if (in_ch.rx_byte != crc_r) begin
          res_status_nxt = ST_CRC_ERR;
        end else if (!id_known) begin
          res_status_nxt = ST_UNKNOWN_ID;
        end else begin
          res_status_nxt = ST_OK;
        end
      end
      default: begin
        // Expecting an id byte; unused phase codes land here too.
        id_nxt    = in_ch.rx_byte;
        len_nxt   = '0;
        count_nxt = '0;
        crc_nxt   = 8'd0;
        phase_nxt = PH_LEN_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ID;
      id_r        <= 8'd0;
      len_r       <= '0;
      count_r     <= '0;
      crc_r       <= 8'd0;
      mask_r      <= ID_MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        id_r        <= id_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
        crc_r       <= crc_nxt;
        out_valid_r <= has_result;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        mask_r <= cfg_ch.accepted_id_mask;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      res_verdict_r <= res_verdict_nxt;
      res_id_r      <= res_id_nxt;
      res_data_r    <= res_data_nxt;
      res_index_r   <= res_index_nxt;
      res_len_r     <= res_len_nxt;
      res_status_r  <= res_status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_verdict     = res_verdict_r;
  assign out_ch.packet_id      = res_id_r;
  assign out_ch.data_byte      = res_data_r;
  assign out_ch.byte_index     = res_index_r;
  assign out_ch.payload_length = res_len_r;
  assign out_ch.status         = res_status_r;

endmodule

>>> rtl/pdf_checker.sv
// Port-level assertions for packet_deframer_crc8_unit, attached by bind.
// Depends on pdf_pkg and the top level's channel interfaces.
module pdf_checker
  import pdf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_verdict,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_byte_index,
  input logic [15:0] out_payload_length,
  input logic [1:0]  out_status
);

  // A stalled result stays valid and holds its index, verdict flag and status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_index)
      && $stable(out_is_verdict) && $stable(out_status))
    else $error("stalled result changed");

  // A payload transfer carries ok status and an index inside the payload.
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_verdict |-> out_status == ST_OK
      && out_byte_index < out_payload_length)
    else $error("bad payload transfer");

  // A verdict has zero data and index and a defined status code.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_verdict |-> out_data_byte == 8'd0 && out_byte_index == 16'd0
      && out_status != 2'd3)
    else $error("bad verdict transfer");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind packet_deframer_crc8_unit pdf_checker u_pdf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_is_verdict     (out_ch.is_verdict),
  .out_data_byte      (out_ch.data_byte),
  .out_byte_index     (out_ch.byte_index),
  .out_payload_length (out_ch.payload_length),
  .out_status         (out_ch.status)
);

>>> verif/tb_packet_deframer_crc8_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_deframer_crc8_unit: byte driver, result monitor and
// an in-bench frame parser with CRC-8 that predicts every payload and verdict transfer.
// Depends on pdf_pkg, the pdf_* channel interfaces and the deframer RTL.
module tb_packet_deframer_crc8_unit;
  import pdf_pkg::*;

  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_BYTES = 270;
  localparam int TAIL_BYTES = 50;

  // Parser states of the prediction model; they mirror the wire format.
  typedef enum logic [2:0] {
    AWAIT_ID,
    AWAIT_LEN_LO,
    AWAIT_LEN_HI,
    IN_PAYLOAD,
    AWAIT_CRC
  } frame_phase_t;

  // One result transfer as the deframer presents it.
  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  packet_id;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] payload_length;
    pdf_status_t status;
  } deframe_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pdf_rx_if  rx_ch ();
  pdf_res_if res_ch ();
  pdf_cfg_if cfg_ch ();

  packet_deframer_crc8_unit #(
    .LENGTH_WIDTH(16)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (rx_ch),
    .out_ch(res_ch),
    .cfg_ch(cfg_ch)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Stream bytes waiting to be offered, and the results the parser model expects.
  logic [7:0]      rx_backlog[$];
  deframe_result_t pending_results[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic        rx_taken = 1'b0;

  // Copy of the deframer state, kept by the monitor alone.
  frame_phase_t frame_phase = AWAIT_ID;
  logic [7:0]   frame_id = 8'h00;
  logic [15:0]  frame_len = 16'h0000;
  logic [15:0]  payload_count = 16'h0000;
  logic [7:0]   payload_crc = 8'h00;
  logic [15:0]  id_mask_model = ID_MASK_RESET;

  // Reflected Maxim CRC-8 over one byte, least significant bit first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC8_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // Advances the parser model by one accepted stream byte. Header bytes yield
  // nothing; a payload byte yields its data transfer and the CRC byte yields
  // the verdict, judged against the mask held at that moment.
  function automatic void deframe_byte(input logic [7:0] rx_byte);
    deframe_result_t r;
    logic            id_known;
    r.is_verdict = 1'b0;
    r.packet_id = frame_id;
    r.data_byte = 8'h00;
    r.byte_index = 16'h0000;
    r.payload_length = frame_len;
    r.status = ST_OK;
    case (frame_phase)
      AWAIT_LEN_LO: begin
        frame_len = {8'h00, rx_byte};
        frame_phase = AWAIT_LEN_HI;
      end
      AWAIT_LEN_HI: begin
        frame_len[15:8] = rx_byte;
        payload_count = 16'h0000;
        payload_crc = 8'h00;
        // An empty payload skips straight to the CRC byte, whose expected value is zero.
        frame_phase = (frame_len == 16'h0000) ? AWAIT_CRC : IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        r.data_byte = rx_byte;
        r.byte_index = payload_count;
        pending_results.push_back(r);
        payload_crc = crc8_next(payload_crc, rx_byte);
        payload_count = payload_count + 16'd1;
        if (payload_count >= frame_len) begin
          frame_phase = AWAIT_CRC;
        end
      end
      AWAIT_CRC: begin
        id_known = (frame_id < 8'd16) && id_mask_model[frame_id[3:0]];
        r.is_verdict = 1'b1;
        // A CRC mismatch outranks an unknown id.
        if (rx_byte != payload_crc) begin
          r.status = ST_CRC_ERR;
        end else if (!id_known) begin
          r.status = ST_UNKNOWN_ID;
        end
        pending_results.push_back(r);
        frame_phase = AWAIT_ID;
      end
      default: begin
        frame_id = rx_byte;
        frame_len = 16'h0000;
        payload_count = 16'h0000;
        payload_crc = 8'h00;
        frame_phase = AWAIT_LEN_LO;
      end
    endcase
  endfunction

  function automatic void queue_rx_byte(input logic [7:0] value);
    rx_backlog.push_back(value);
    bytes_queued++;
  endfunction

  // Queues one whole frame. A nonzero crc_flip corrupts the CRC byte.
  function automatic void queue_frame(input logic [7:0] id, ref logic [7:0] body[$],
                                      input logic [7:0] crc_flip);
    logic [7:0]  crc;
    logic [15:0] len;
    crc = 8'h00;
    len = 16'(body.size());
    queue_rx_byte(id);
    queue_rx_byte(len[7:0]);
    queue_rx_byte(len[15:8]);
    foreach (body[i]) begin
      queue_rx_byte(body[i]);
      crc = crc8_next(crc, body[i]);
    end
    queue_rx_byte(crc ^ crc_flip);
  endfunction

  // Random frame: mostly low ids and short payloads with a good CRC, some
  // foreign ids, a few longer payloads, most of which reach the high length
  // byte, and some corrupted or plain random CRC bytes.
  function automatic void queue_random_frame();
    logic [7:0]  body[$];
    logic [7:0]  id;
    logic [7:0]  flip;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(99);
    id = (pick < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 10) begin
      len = 0;
    end else if (pick < 95) begin
      len = $urandom_range(12, 1);
    end else begin
      len = $urandom_range(300, 250);
    end
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom_range(255)));
    end
    pick = $urandom_range(99);
    if (pick < 78) begin
      flip = 8'h00;
    end else if (pick < 95) begin
      flip = 8'($urandom_range(255, 1));
    end else begin
      flip = 8'($urandom_range(255));
    end
    queue_frame(id, body, flip);
  endfunction

  function automatic void queue_random_traffic(input int unsigned min_bytes);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < min_bytes) begin
      queue_random_frame();
    end
  endfunction

  // Directed frames under the reset mask: empty payload, unknown low id, CRC
  // error on an id that is also unknown, highest accepted id, and id 16.
  function automatic void queue_directed_frames();
    logic [7:0] body[$];
    body = {};
    queue_frame(8'd3, body, 8'h00);
    body = {8'hFF};
    queue_frame(8'd0, body, 8'h00);
    body = {8'h00, 8'h80};
    queue_frame(8'hFF, body, 8'h5A);
    body = {8'hA5};
    queue_frame(8'd15, body, 8'h00);
    body = {};
    queue_frame(8'd16, body, 8'h00);
  endfunction

  // Waits, at falling edges, until every queued byte has been transferred and
  // every expected result has come back, then lets the output register settle.
  task automatic wait_until_idle();
    do begin
      @(negedge clk);
    end while (bytes_accepted != bytes_queued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mask writes happen only while the block is idle.
  task automatic write_id_mask(input logic [15:0] mask);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.accepted_id_mask <= mask;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Byte driver. A byte stays on the channel until its transfer; the next one is
  // loaded in the same assignment, so valid is never dropped and raised in one step.
  always @(negedge clk) begin
    if (rst_n && (!rx_ch.valid || rx_taken)) begin
      if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= rx_backlog.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver. A new hold-off request keeps ready low for a long stretch,
  // counted here, so the output register fills and the byte input stalls.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Every channel is sampled at the rising edge; the model is advanced
  // for each byte transfer and each result transfer is checked against the oldest
  // expectation. A result is registered in the deframer, so it trails its byte.
  always @(posedge clk) begin
    deframe_result_t seen;
    deframe_result_t want;
    rx_taken <= rst_n && rx_ch.valid && rx_ch.ready;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      id_mask_model = cfg_ch.accepted_id_mask;
    end
    if (rst_n && rx_ch.valid && rx_ch.ready) begin
      bytes_accepted <= bytes_accepted + 1;
      deframe_byte(rx_ch.rx_byte);
    end
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen.is_verdict = res_ch.is_verdict;
      seen.packet_id = res_ch.packet_id;
      seen.data_byte = res_ch.data_byte;
      seen.byte_index = res_ch.byte_index;
      seen.payload_length = res_ch.payload_length;
      seen.status = res_ch.status;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: actual verdict=%0d id=%02h data=%02h",
                 $time, seen.is_verdict, seen.packet_id, seen.data_byte,
                 " index=%0d length=%0d status=%0d",
                 seen.byte_index, seen.payload_length, seen.status);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display("%0t: result mismatch: expected verdict=%0d id=%02h data=%02h",
                   $time, want.is_verdict, want.packet_id, want.data_byte,
                   " index=%0d length=%0d status=%0d",
                   want.byte_index, want.payload_length, want.status);
          $display("%0t:                  actual verdict=%0d id=%02h data=%02h",
                   $time, seen.is_verdict, seen.packet_id, seen.data_byte,
                   " index=%0d length=%0d status=%0d",
                   seen.byte_index, seen.payload_length, seen.status);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sequencer: reset, then four phases of traffic with a mask write between them.
  // Queue filling and idle settings change only at rising edges, while the driver
  // and receiver act at falling edges.
  initial begin
    rst_n = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.accepted_id_mask = 16'h0000;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one runs under the reset mask with a mostly stalling receiver.
    @(posedge clk);
    send_idle_pct = 10;
    recv_idle_pct = 62;
    queue_directed_frames();
    queue_random_traffic(PHASE_BYTES);
    wait_until_idle();

    // No id accepted, and the sender is now the slow side.
    write_id_mask(16'h0000);
    @(posedge clk);
    send_idle_pct = 62;
    recv_idle_pct = 10;
    queue_random_traffic(PHASE_BYTES);
    wait_until_idle();

    // Every low id accepted; full rate, opened by a long receiver hold-off.
    write_id_mask(16'hFFFF);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random_traffic(PHASE_BYTES);
    wait_until_idle();

    // A random mask and a little more traffic at full rate.
    write_id_mask(16'($urandom_range(65535)));
    @(posedge clk);
    queue_random_traffic(TAIL_BYTES);
    wait_until_idle();

    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
